// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port monitor of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lmf_pkg.sv =====
// Package of the scrolling LED matrix framer: codes, constants and shared types.
`default_nettype none

package lmf_pkg;

  // Default width of the column line
  localparam int LINE_COLUMNS_DEF = 256;

  // Fixed geometry
  localparam int WIN_COLS    = 64;   // columns in one frame
  localparam int WCW         = 7;    // counter that can hold WIN_COLS
  localparam int MARGIN      = 11;   // blank columns after the text
  localparam int BEEP_PERIOD = 20;   // scroll steps between beep checks
  localparam int PW          = 10;   // scroll position width
  localparam int MW          = 5;    // width of position mod BEEP_PERIOD
  localparam int MOD_COLS    = 16;   // columns (and rows) of one module
  localparam int MOD_LAST    = 15;   // last column or row of a module

  // Commands
  localparam logic [1:0] CMD_OR_COLUMN = 2'd0;
  localparam logic [1:0] CMD_CLEAR     = 2'd1;
  localparam logic [1:0] CMD_FRAME     = 2'd2;
  localparam logic [1:0] CMD_SCROLL    = 2'd3;

  // Register indexes
  localparam logic [0:0] REG_TEXT_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEAD_FIRST = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SC_MOD,
    ST_SC_RUN,
    ST_SC_UPD,
    ST_FR_LOAD,
    ST_FR_WAIT,
    ST_FR_EMIT
  } state_t;

  // Control from the sequencer to the transpose stage
  typedef struct packed {
    logic       cap;        // column read data valid this cycle
    logic [3:0] cap_slot;   // slot that takes it
    logic       src_win;    // frame comes from the window
    logic       emit;       // load the output register
    logic [1:0] module_res;
    logic [3:0] row;
    logic       mirror;
    logic       beep;
    logic       wrapped;
    logic       last;
  } frame_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lmf_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module lmf_ram #(
  parameter int DEPTH = lmf_pkg::LINE_COLUMNS_DEF,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lmf_transpose.sv =====
// Column buffer of one module and row word assembly with the output register.
`default_nettype none

module lmf_transpose (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lmf_pkg::frame_ctl_t ctl,
  input  wire logic [31:0]        store_rdata,
  input  wire logic [31:0]        win_rdata,
  output logic                    out_free,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [39:0]             m_tdata,   // module_res, row, red_row, green_row, beep, wrapped
  output logic                    m_tlast
);

  logic [15:0] col_red   [lmf_pkg::MOD_COLS];
  logic [15:0] col_green [lmf_pkg::MOD_COLS];
  logic [31:0] cap_word;
  logic [3:0]  bit_sel;
  logic [15:0] red_row;
  logic [15:0] green_row;

  // Capture one column per read
  assign cap_word = ctl.src_win ? win_rdata : store_rdata;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      col_red[ctl.cap_slot]   <= cap_word[15:0];
      col_green[ctl.cap_slot] <= cap_word[31:16];
    end
  end

  // Row word: bit p taken from buffered column p
  assign bit_sel = ctl.mirror ? ~ctl.row : ctl.row;

  always_comb begin
    for (int p = 0; p < lmf_pkg::MOD_COLS; p++) begin
      red_row[p]   = col_red[p][bit_sel];
      green_row[p] = col_green[p][bit_sel];
    end
  end

  // Output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      m_tdata <= {ctl.wrapped, ctl.beep, green_row, red_row, ctl.row, ctl.module_res};
      m_tlast <= ctl.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scrolling_led_matrix_framer.sv =====
// Scrolling LED matrix framer: top level with command sequencer and column stores.
//
// Usage: commands arrive on the s_ channel (tuser = command, tdata = column
// index, red bits, green bits). Command 0 ORs pixels into a stored column,
// command 1 clears stores, window and scroll position (one store entry a
// cycle). Command 2 emits a frame of 64 row word transfers on the m_ channel,
// the 64th marked by tlast. Command 3 first reduces the position by the
// scroll length, one subtraction a cycle, copies the window from the store
// (up to 64 reads), then emits the frame. Per module, a frame makes 16 reads
// through the store or window read port, waits for the read data and emits
// 16 row words. One command is worked on at a time; s_tready is high while
// idle, also while the final row word still waits in the output register.
// Reset (synchronous, rst high) resets the configuration and control
// registers and runs the same clearing sweep as command 1, with s_tready low.
// A stalled receiver holds the output register and the frame simply waits.
// Configuration (text_width index 0, head_first index 1) must be written only
// while idle; the block itself does not enforce this.
`default_nettype none

module scrolling_led_matrix_framer #(
  parameter int LINE_COLUMNS = lmf_pkg::LINE_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // column_index, red_bits, green_bits
  input  wire logic [1:0]  s_tuser,   // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // module_res, row, red_row, green_row, beep, wrapped
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int AW = $clog2(LINE_COLUMNS);
  localparam int LW = ($clog2(LINE_COLUMNS + 1) > 10) ? $clog2(LINE_COLUMNS + 1) : 10;
  localparam int PW = lmf_pkg::PW;
  localparam int MW = lmf_pkg::MW;

  lmf_pkg::state_t state, state_next;

  // Configuration
  logic [8:0] text_width;
  logic       head_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_width <= 9'd0;
      head_first <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmf_pkg::REG_TEXT_WIDTH: text_width <= cfg_data;
        lmf_pkg::REG_HEAD_FIRST: head_first <= cfg_data[0];
      endcase
    end
  end

  // Working registers
  logic [AW-1:0]          clr_cnt;
  logic [AW-1:0]          col_addr;
  logic [31:0]            or_bits;
  logic [LW-1:0]          rem;
  logic [LW-1:0]          idx;
  logic [lmf_pkg::WCW-1:0] wcnt;
  logic [PW-1:0]          pos;
  logic [MW-1:0]          pos_mod;
  logic                   beep;
  logic                   wrapped;
  logic [1:0]             md;
  logic [3:0]             ld_cnt;
  logic [3:0]             rd;
  logic                   sc_pend;
  logic [5:0]             sc_slot;
  logic                   fr_pend;
  logic [3:0]             fr_slot;

  // Scroll length and window count
  logic [LW-1:0] span_raw, span, span_m1, lim, idx_inc, pos_lim;
  logic          run;
  logic          clear_done;
  logic          s_xfer;
  logic          col_ok;

  assign span_raw = LW'(text_width) + LW'(lmf_pkg::MARGIN);
  assign span     = (span_raw > LW'(LINE_COLUMNS)) ? LW'(LINE_COLUMNS) : span_raw;
  assign span_m1  = span - LW'(1);
  assign lim      = (span_m1 > LW'(lmf_pkg::WIN_COLS)) ? LW'(lmf_pkg::WIN_COLS) : span_m1;
  assign run      = LW'(wcnt) < lim;
  assign idx_inc  = idx + LW'(1);
  assign pos_lim  = span_raw;

  assign clear_done = (clr_cnt == AW'(LINE_COLUMNS - 1));
  assign s_xfer     = s_tvalid && s_tready;
  assign col_ok     = (32'(s_tdata[7:0]) < LINE_COLUMNS);

  // Position update of a scroll step
  logic [PW-1:0] pos_inc;
  logic [MW-1:0] pos_mod_inc;
  assign pos_inc     = pos + PW'(1);
  assign pos_mod_inc = (pos_mod == MW'(lmf_pkg::BEEP_PERIOD - 1)) ? MW'(0) : pos_mod + MW'(1);

  // Frame column address, mirrored for head-first mounting
  logic [5:0] frame_col;
  assign frame_col = head_first ? ~{md, ld_cnt} : {md, ld_cnt};

  // Memory ports
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [31:0]   st_wdata, st_rdata;
  logic          win_we;
  logic [5:0]    win_waddr;
  logic [31:0]   win_wdata, win_rdata;
  logic          out_free;
  logic          emit;

  lmf_pkg::frame_ctl_t fctl;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmf_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    emit       = 1'b0;
    st_we      = 1'b0;
    st_waddr   = clr_cnt;
    st_wdata   = 32'd0;
    st_raddr   = AW'(frame_col);
    win_we     = sc_pend;
    win_waddr  = sc_slot;
    win_wdata  = st_rdata;
    unique case (state)
      lmf_pkg::ST_CLEAR: begin
        st_we     = 1'b1;
        win_we    = ({1'b0, clr_cnt} < (AW + 1)'(lmf_pkg::WIN_COLS));
        win_waddr = clr_cnt[5:0];
        win_wdata = 32'd0;
        if (clear_done) begin
          state_next = lmf_pkg::ST_IDLE;
        end
      end
      lmf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (s_tuser)
            lmf_pkg::CMD_OR_COLUMN: state_next = col_ok ? lmf_pkg::ST_RMW_RD : lmf_pkg::ST_IDLE;
            lmf_pkg::CMD_CLEAR:     state_next = lmf_pkg::ST_CLEAR;
            lmf_pkg::CMD_FRAME:     state_next = lmf_pkg::ST_FR_LOAD;
            lmf_pkg::CMD_SCROLL:    state_next = lmf_pkg::ST_SC_MOD;
          endcase
        end
      end
      lmf_pkg::ST_RMW_RD: begin
        st_raddr   = col_addr;
        state_next = lmf_pkg::ST_RMW_WR;
      end
      lmf_pkg::ST_RMW_WR: begin
        st_we      = 1'b1;
        st_waddr   = col_addr;
        st_wdata   = st_rdata | or_bits;
        state_next = lmf_pkg::ST_IDLE;
      end
      lmf_pkg::ST_SC_MOD: begin
        if (rem < span) begin
          state_next = lmf_pkg::ST_SC_RUN;
        end
      end
      lmf_pkg::ST_SC_RUN: begin
        st_raddr = idx[AW-1:0];
        if (!run) begin
          state_next = lmf_pkg::ST_SC_UPD;
        end
      end
      lmf_pkg::ST_SC_UPD: begin
        state_next = lmf_pkg::ST_FR_LOAD;
      end
      lmf_pkg::ST_FR_LOAD: begin
        if (ld_cnt == 4'(lmf_pkg::MOD_LAST)) begin
          state_next = lmf_pkg::ST_FR_WAIT;
        end
      end
      lmf_pkg::ST_FR_WAIT: begin
        state_next = lmf_pkg::ST_FR_EMIT;
      end
      lmf_pkg::ST_FR_EMIT: begin
        emit = out_free;
        if (out_free && rd == 4'(lmf_pkg::MOD_LAST)) begin
          state_next = (md == 2'd3) ? lmf_pkg::ST_IDLE : lmf_pkg::ST_FR_LOAD;
        end
      end
    endcase
  end

  // Counters, scroll position and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pos     <= '0;
      pos_mod <= '0;
      beep    <= 1'b1;
      wrapped <= 1'b0;
      sc_pend <= 1'b0;
      fr_pend <= 1'b0;
      md      <= 2'd0;
      ld_cnt  <= 4'd0;
      rd      <= 4'd0;
    end else begin
      sc_pend <= (state == lmf_pkg::ST_SC_RUN) && run;
      fr_pend <= (state == lmf_pkg::ST_FR_LOAD);
      case (state)
        lmf_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
        end
        lmf_pkg::ST_IDLE: begin
          if (s_xfer && s_tuser == lmf_pkg::CMD_CLEAR) begin
            clr_cnt <= '0;
            pos     <= '0;
            pos_mod <= '0;
            beep    <= 1'b1;
          end
          if (s_xfer && s_tuser == lmf_pkg::CMD_FRAME) begin
            wrapped <= 1'b0;
          end
        end
        lmf_pkg::ST_SC_UPD: begin
          if (pos_mod_inc == MW'(0)) begin
            beep <= 1'b0;
          end
          if (LW'(pos_inc) > pos_lim) begin
            pos     <= PW'(1);
            pos_mod <= MW'(1);
            wrapped <= 1'b1;
          end else begin
            pos     <= pos_inc;
            pos_mod <= pos_mod_inc;
            wrapped <= 1'b0;
          end
        end
        lmf_pkg::ST_FR_LOAD: begin
          ld_cnt <= ld_cnt + 4'd1;
        end
        lmf_pkg::ST_FR_EMIT: begin
          if (out_free) begin
            rd <= rd + 4'd1;
            if (rd == 4'(lmf_pkg::MOD_LAST)) begin
              md <= md + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: command fields, modulo reduction, window walk
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      col_addr <= AW'(s_tdata[7:0]);
      or_bits  <= {s_tdata[39:24], s_tdata[23:8]};
      rem      <= LW'(pos);
    end
    if (state == lmf_pkg::ST_SC_MOD) begin
      if (rem >= span) begin
        rem <= rem - span;
      end else begin
        idx  <= rem;
        wcnt <= '0;
      end
    end
    if (state == lmf_pkg::ST_SC_RUN && run) begin
      idx     <= (idx_inc == span) ? LW'(0) : idx_inc;
      wcnt    <= wcnt + lmf_pkg::WCW'(1);
      sc_slot <= wcnt[5:0];
    end
    if (state == lmf_pkg::ST_FR_LOAD) begin
      fr_slot <= ld_cnt;
    end
  end

  // Column stores: red in the low half, green in the high half
  lmf_ram #(
    .DEPTH (LINE_COLUMNS),
    .WIDTH (32)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  lmf_ram #(
    .DEPTH (lmf_pkg::WIN_COLS),
    .WIDTH (32)
  ) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (frame_col),
    .rdata (win_rdata)
  );

  // Frame control to the transpose stage
  always_comb begin
    fctl.cap        = fr_pend;
    fctl.cap_slot   = fr_slot;
    fctl.src_win    = (pos != PW'(0));
    fctl.emit       = emit;
    fctl.module_res = md;
    fctl.row        = rd;
    fctl.mirror     = head_first;
    fctl.beep       = beep;
    fctl.wrapped    = wrapped;
    fctl.last       = (md == 2'd3) && (rd == 4'(lmf_pkg::MOD_LAST));
  end

  lmf_transpose u_transpose (
    .clk         (clk),
    .rst         (rst),
    .ctl         (fctl),
    .store_rdata (st_rdata),
    .win_rdata   (win_rdata),
    .out_free    (out_free),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/lmf_port_monitor.sv =====
// Port-level assertions of the framer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lmf_port_monitor (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,   // module_res, row, red_row, green_row, beep, wrapped
  input wire logic        m_tlast
);

  logic stall;
  logic last_pos;

  assign stall    = m_tvalid && !m_tready;
  assign last_pos = (m_tdata[5:2] == 4'(lmf_pkg::MOD_LAST)) && (m_tdata[1:0] == 2'd3);

  // A stalled row word holds
  `ASSERT_CLKD(a_out_hold, clk, rst, stall |=> m_tvalid && $stable(m_tdata), "row word changed")

  // Reset empties the output register and starts the clearing sweep
  `ASSERT_ALWAYS(a_rst_out, clk, rst |=> !m_tvalid, "output valid after reset")
  `ASSERT_ALWAYS(a_rst_busy, clk, rst |=> !s_tready, "command taken during clearing sweep")

  // The frame ends on module 3, row 15
  `ASSERT_CLKD(a_last_pos, clk, rst, m_tvalid && m_tlast |-> last_pos, "tlast on wrong row word")

endmodule

bind scrolling_led_matrix_framer lmf_port_monitor u_port_monitor (.*);

`default_nettype wire

// ===== test/scrolling_led_matrix_framer_tb.sv =====
// Testbench of the scrolling LED matrix framer: stream stimulus, row word prediction, checks.
`timescale 1ns / 1ps

module scrolling_led_matrix_framer_tb;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int SETTLE_CYCLES  = 300;   // covers a clearing sweep
  localparam int HOLD_CYCLES    = 600;   // long receiver hold-off

  // One row word as it leaves the block
  typedef struct {
    logic [1:0]  module_res;
    logic [3:0]  row;
    logic [15:0] red_row;
    logic [15:0] green_row;
    logic        beep;
    logic        wrapped;
    logic        last;
  } row_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // column_index, red_bits, green_bits
  logic [1:0]  s_tuser = lmf_pkg::CMD_OR_COLUMN;  // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // module_res, row, red_row, green_row, beep, wrapped
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = lmf_pkg::REG_TEXT_WIDTH;
  logic [8:0]  cfg_data = '0;

  // Shadow state of the display
  logic [15:0] col_red   [lmf_pkg::LINE_COLUMNS_DEF];
  logic [15:0] col_green [lmf_pkg::LINE_COLUMNS_DEF];
  logic [15:0] win_red   [lmf_pkg::WIN_COLS];
  logic [15:0] win_green [lmf_pkg::WIN_COLS];
  int          scroll_at;
  logic        beep_on;
  int          text_width;
  logic        head_first;

  row_word_t pending_rows[$];
  int        error_count = 0;
  int        rows_seen = 0;
  int        quiet_cycles = 0;
  int        hold_left = 0;
  logic      hold_req = 1'b0;
  logic      hold_done = 1'b0;
  logic      no_idle = 1'b0;

  scrolling_led_matrix_framer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow state after reset
  task automatic reset_display();
    foreach (col_red[i]) begin
      col_red[i]   = '0;
      col_green[i] = '0;
    end
    foreach (win_red[i]) begin
      win_red[i]   = '0;
      win_green[i] = '0;
    end
    scroll_at  = 0;
    beep_on    = 1'b1;
    text_width = 0;
    head_first = 1'b0;
  endtask

  // Window copy and position advance; returns 1 when a pass completes
  function automatic logic scroll_window();
    int len;
    int idx;
    len = text_width + lmf_pkg::MARGIN;
    if (len > lmf_pkg::LINE_COLUMNS_DEF) len = lmf_pkg::LINE_COLUMNS_DEF;
    for (int c = 0; c + 1 < len && c < lmf_pkg::WIN_COLS; c++) begin
      idx = (scroll_at + c) % len;
      win_red[c]   = col_red[idx];
      win_green[c] = col_green[idx];
    end
    scroll_at++;
    if (scroll_at % lmf_pkg::BEEP_PERIOD == 0) beep_on = 1'b0;
    if (scroll_at > text_width + lmf_pkg::MARGIN) begin
      scroll_at = 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Transpose 64 columns into 4 modules of 16 row words
  task automatic queue_frame_rows(input logic wrapped);
    row_word_t w;
    int col;
    int bit_sel;
    logic [15:0] cr;
    logic [15:0] cg;
    for (int md = 0; md < 4; md++) begin
      for (int rd = 0; rd < lmf_pkg::MOD_COLS; rd++) begin
        w.red_row   = '0;
        w.green_row = '0;
        for (int p = 0; p < lmf_pkg::MOD_COLS; p++) begin
          if (head_first) begin
            col     = (lmf_pkg::MOD_LAST - p) + (3 - md) * lmf_pkg::MOD_COLS;
            bit_sel = lmf_pkg::MOD_LAST - rd;
          end else begin
            col     = p + md * lmf_pkg::MOD_COLS;
            bit_sel = rd;
          end
          cr = (scroll_at != 0) ? win_red[col]   : col_red[col];
          cg = (scroll_at != 0) ? win_green[col] : col_green[col];
          w.red_row[p]   = cr[bit_sel];
          w.green_row[p] = cg[bit_sel];
        end
        w.module_res = md[1:0];
        w.row        = rd[3:0];
        w.beep       = beep_on;
        w.wrapped    = wrapped;
        w.last       = (md == 3 && rd == lmf_pkg::MOD_LAST);
        pending_rows.push_back(w);
      end
    end
  endtask

  // Effect of one accepted command on the display
  task automatic apply_command(input logic [1:0] cmd, input logic [7:0] col,
                               input logic [15:0] rb, input logic [15:0] gb);
    logic wrapped;
    case (cmd)
      lmf_pkg::CMD_OR_COLUMN: begin
        col_red[col]   = col_red[col] | rb;
        col_green[col] = col_green[col] | gb;
      end
      lmf_pkg::CMD_CLEAR: begin
        foreach (col_red[i]) begin
          col_red[i]   = '0;
          col_green[i] = '0;
        end
        foreach (win_red[i]) begin
          win_red[i]   = '0;
          win_green[i] = '0;
        end
        scroll_at = 0;
        beep_on   = 1'b1;
      end
      lmf_pkg::CMD_FRAME: queue_frame_rows(1'b0);
      default: begin
        wrapped = scroll_window();
        queue_frame_rows(wrapped);
      end
    endcase
  endtask

  // One command transfer on the input stream
  task automatic send_command(input logic [1:0] cmd, input logic [7:0] col,
                              input logic [15:0] rb, input logic [15:0] gb);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {gb, rb, col};
    do @(posedge clk); while (!s_tready);
    apply_command(cmd, col, rb, gb);
  endtask

  // Wait for all row words, then for the block to go quiet
  task automatic drain_rows();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [8:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == lmf_pkg::REG_TEXT_WIDTH) text_width = int'(value);
    else head_first = value[0];
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("row word %0d: %s is %0h, expected %0h", rows_seen, field, got, want);
    error_count++;
  endtask

  // Column writes, OR accumulation and plain frames from the store
  task automatic test_store_frames();
    send_command(lmf_pkg::CMD_FRAME, 8'd0, 16'h0000, 16'h0000);
    send_command(lmf_pkg::CMD_OR_COLUMN, 8'd0, 16'hFFFF, 16'h0000);
    send_command(lmf_pkg::CMD_OR_COLUMN, 8'd63, 16'h0000, 16'hFFFF);
    send_command(lmf_pkg::CMD_OR_COLUMN, 8'd255, 16'hA5A5, 16'h5A5A);
    send_command(lmf_pkg::CMD_OR_COLUMN, 8'd17, 16'h8001, 16'h0001);
    send_command(lmf_pkg::CMD_OR_COLUMN, 8'd17, 16'h0100, 16'h8000);
    send_command(lmf_pkg::CMD_OR_COLUMN, 8'd32, 16'h0000, 16'h0000);
    send_command(lmf_pkg::CMD_FRAME, 8'd255, 16'hFFFF, 16'hFFFF);
  endtask

  // Upside-down mounting
  task automatic test_mirror();
    drain_rows();
    write_reg(lmf_pkg::REG_HEAD_FIRST, 9'd1);
    send_command(lmf_pkg::CMD_FRAME, 8'd0, 16'h0000, 16'h0000);
  endtask

  // Shortest scroll length, run through a full pass and past it
  task automatic test_scroll_wrap();
    drain_rows();
    write_reg(lmf_pkg::REG_TEXT_WIDTH, 9'd0);
    repeat (13) send_command(lmf_pkg::CMD_SCROLL, 8'd0, 16'h0000, 16'h0000);
  endtask

  // Clear drops stores, window and position but keeps the registers
  task automatic test_clear();
    send_command(lmf_pkg::CMD_CLEAR, 8'd0, 16'h0000, 16'h0000);
    send_command(lmf_pkg::CMD_FRAME, 8'd0, 16'h0000, 16'h0000);
    send_command(lmf_pkg::CMD_SCROLL, 8'd0, 16'h0000, 16'h0000);
  endtask

  // Random command mix over a range of register settings
  task automatic test_random();
    int widths[7];
    int lenv;
    int r;
    logic [1:0]  cmd;
    logic [7:0]  col;
    logic [15:0] rb;
    logic [15:0] gb;
    widths = '{0, int'($urandom_range(9, 1)), int'($urandom_range(40, 10)), 256,
               int'($urandom_range(255, 41)), 511, int'($urandom_range(510, 257))};
    for (int ph = 0; ph < 7; ph++) begin
      drain_rows();
      write_reg(lmf_pkg::REG_TEXT_WIDTH, widths[ph][8:0]);
      write_reg(lmf_pkg::REG_HEAD_FIRST, 9'(ph[0]));
      no_idle = (ph == 2);
      lenv = text_width + lmf_pkg::MARGIN;
      if (lenv > lmf_pkg::LINE_COLUMNS_DEF) lenv = lmf_pkg::LINE_COLUMNS_DEF;
      for (int n = 0; n < 56; n++) begin
        r = int'($urandom_range(99));
        if (r < 45) cmd = lmf_pkg::CMD_OR_COLUMN;
        else if (r < 85) cmd = lmf_pkg::CMD_SCROLL;
        else if (r < 96) cmd = lmf_pkg::CMD_FRAME;
        else cmd = lmf_pkg::CMD_CLEAR;
        if ($urandom_range(3) != 0) col = 8'($urandom_range(lenv - 1, 0));
        else col = 8'($urandom_range(255, 0));
        // sparse pixels mostly, so columns do not saturate
        if ($urandom_range(4) == 0) begin
          rb = 16'($urandom);
          gb = 16'($urandom);
        end else begin
          rb = 16'($urandom & $urandom & $urandom);
          gb = 16'($urandom & $urandom & $urandom);
        end
        send_command(cmd, col, rb, gb);
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off while frames keep being offered
  task automatic test_backpressure();
    drain_rows();
    write_reg(lmf_pkg::REG_TEXT_WIDTH, 9'd5);
    hold_req = 1'b1;
    repeat (3) send_command(lmf_pkg::CMD_SCROLL, 8'd0, 16'h0000, 16'h0000);
    send_command(lmf_pkg::CMD_OR_COLUMN, 8'd3, 16'h1234, 16'h4321);
    repeat (3) send_command(lmf_pkg::CMD_SCROLL, 8'd0, 16'h0000, 16'h0000);
  endtask

  // Receiver readiness
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 12);
    end
  end

  // Row word check against the oldest expectation
  always @(posedge clk) begin : check_rows
    row_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch("unexpected row word, position", int'(m_tdata[5:0]), 0);
      end else begin
        w = pending_rows.pop_front();
        if (m_tdata[1:0] !== w.module_res)
          report_mismatch("module", int'(m_tdata[1:0]), int'(w.module_res));
        if (m_tdata[5:2] !== w.row)
          report_mismatch("row", int'(m_tdata[5:2]), int'(w.row));
        if (m_tdata[21:6] !== w.red_row)
          report_mismatch("red_row", int'(m_tdata[21:6]), int'(w.red_row));
        if (m_tdata[37:22] !== w.green_row)
          report_mismatch("green_row", int'(m_tdata[37:22]), int'(w.green_row));
        if (m_tdata[38] !== w.beep)
          report_mismatch("beep", int'(m_tdata[38]), int'(w.beep));
        if (m_tdata[39] !== w.wrapped)
          report_mismatch("wrapped", int'(m_tdata[39]), int'(w.wrapped));
        if (m_tlast !== w.last)
          report_mismatch("last", int'(m_tlast), int'(w.last));
      end
      rows_seen++;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("scrolling_led_matrix_framer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    reset_display();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_store_frames();
    test_mirror();
    test_scroll_wrap();
    test_clear();
    drain_rows();
    write_reg(lmf_pkg::REG_HEAD_FIRST, 9'd0);
    test_random();
    test_backpressure();
    drain_rows();
    if (error_count == 0) begin
      $display("scrolling_led_matrix_framer_tb: done, clean");
    end else begin
      $display("scrolling_led_matrix_framer_tb: done, errors");
    end
    $finish;
  end

endmodule
